@@ hw/rtl/tlvchk_pkg.sv @@
// Shared types, status codes and CRC helpers for the TlvInfo image checker.
// No dependencies; imported by tlvinfo_image_checker and its assertion checker.
`timescale 1ns / 1ps

package tlvchk_pkg;

    localparam int MAX_TOTAL_LEN_DEF = 2037;
    localparam int CRC_TLV_CODE_DEF  = 254;

    localparam logic [1:0] CHK_VALID     = 2'd0;
    localparam logic [1:0] CHK_BAD_HDR   = 2'd1;
    localparam logic [1:0] CHK_NO_CRC    = 2'd2;
    localparam logic [1:0] CHK_MISMATCH  = 2'd3;

    localparam logic [1:0] LKP_FOUND     = 2'd0;
    localparam logic [1:0] LKP_NOT_FOUND = 2'd1;
    localparam logic [1:0] LKP_INVALID   = 2'd2;

    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_MLEN = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam logic [7:0] TLV_TYPE_NULL = 8'h00;
    localparam logic [7:0] TLV_TYPE_FF   = 8'hFF;
    localparam logic [7:0] CRC_TLV_LEN   = 8'd4;
    localparam logic [7:0] HDR_VERSION   = 8'd1;
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_image;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  check_status;
        logic [1:0]  lookup_status;
        logic [10:0] found_offset;
        logic [7:0]  found_length;
        logic [31:0] computed_crc;
        logic [31:0] image_crc;
    } t_out_beat;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0: v = 8'h54;
            3'd1: v = 8'h6C;
            3'd2: v = 8'h76;
            3'd3: v = 8'h49;
            3'd4: v = 8'h6E;
            3'd5: v = 8'h66;
            3'd6: v = 8'h6F;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/tlvinfo_image_checker.sv @@
// TlvInfo image checker top level: header check, CRC-32, TLV walk, result skid.
// Depends on tlvchk_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one image byte
//   per beat; start_of_image marks byte 0 and abandons any image in progress.
//   Bytes with start_of_image low while no image is open are dropped.
//   Output channel (o_out_valid / i_out_stall / o_out_data) carries one result
//   beat per image: at byte 10 when the header is bad, else at byte
//   10 + total length.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the TLV
//   type code to locate; write only while no image is open.
//   Throughput: one byte per cycle while o_in_stall is low. The CRC update,
//   header compares and TLV walk are combinational between the state registers.
//   The result is registered in the output register, or in the skid register.
//   Receiver stall: the result holds in the output register; a second result
//   lands in a skid register, and o_in_stall rises only while that skid
//   register is occupied.
//   Reset (synchronous, active low) clears the lookup code, closes any image
//   and empties both output registers.
module tlvinfo_image_checker #(
    parameter int MAX_TOTAL_LEN = tlvchk_pkg::MAX_TOTAL_LEN_DEF,
    parameter int CRC_TLV_CODE  = tlvchk_pkg::CRC_TLV_CODE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  tlvchk_pkg::t_in_beat   i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output tlvchk_pkg::t_out_beat  o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [7:0]             i_cfg_data
);
    import tlvchk_pkg::*;

    localparam int PW = $clog2(MAX_TOTAL_LEN + 12);
    localparam int LW = $clog2(MAX_TOTAL_LEN + 1);
    localparam int SW = PW + 9;

    logic [7:0]    r_lookup_code;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_active, n_active;
    logic          r_hdr_good, n_hdr_good;
    logic [LW-1:0] r_total, n_total;
    logic [31:0]   r_crc, n_crc;
    logic [31:0]   r_stored, n_stored;
    logic          r_crc_tlv_good, n_crc_tlv_good;
    logic [PW-1:0] r_next_off, n_next_off;
    logic [1:0]    r_phase, n_phase;
    logic [1:0]    r_lookup, n_lookup;
    logic [PW-1:0] r_match_off, n_match_off;
    logic [7:0]    r_match_len, n_match_len;

    logic          r_ovalid, n_ovalid;
    t_out_beat     r_obeat, n_obeat;
    logic          r_skid_valid, n_skid_valid;
    t_out_beat     r_skid, n_skid;

    logic          in_acc;
    logic          res_valid;
    t_out_beat     res;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_obeat;

    always_comb begin
        logic [7:0]     b;
        logic [PW-1:0]  p;
        logic [15:0]    len16;
        logic [PW:0]    p_plus4;
        logic [PW:0]    crc_lim;
        logic [PW-1:0]  end_pos;
        logic [SW-1:0]  nx;
        logic [PW+10:0] moff_ext;
        logic [31:0]    crc_out;

        n_pos          = r_pos;
        n_active       = r_active;
        n_hdr_good     = r_hdr_good;
        n_total        = r_total;
        n_crc          = r_crc;
        n_stored       = r_stored;
        n_crc_tlv_good = r_crc_tlv_good;
        n_next_off     = r_next_off;
        n_phase        = r_phase;
        n_lookup       = r_lookup;
        n_match_off    = r_match_off;
        n_match_len    = r_match_len;
        res_valid      = 1'b0;
        res            = '0;
        b              = i_in_data.data_byte;
        p              = '0;
        len16          = '0;
        p_plus4        = '0;
        crc_lim        = '0;
        end_pos        = '0;
        nx             = '0;
        moff_ext       = '0;
        crc_out        = '0;

        if (in_acc && i_in_data.start_of_image) begin
            n_pos          = '0;
            n_active       = 1'b1;
            n_hdr_good     = 1'b1;
            n_total        = '0;
            n_crc          = '1;
            n_stored       = '0;
            n_crc_tlv_good = 1'b0;
            n_next_off     = PW'(11);
            n_phase        = PH_TYPE;
            n_lookup       = LKP_NOT_FOUND;
            n_match_off    = '0;
            n_match_len    = '0;
        end

        if (in_acc && n_active) begin
            p = n_pos;
            if (p < PW'(8) && b != sig_byte(p[2:0])) begin
                n_hdr_good = 1'b0;
            end
            if (p == PW'(8) && b != HDR_VERSION) begin
                n_hdr_good = 1'b0;
            end
            if (p == PW'(10)) begin
                len16 = {n_stored[7:0], b};
                if (len16 > 16'(MAX_TOTAL_LEN)) begin
                    n_hdr_good = 1'b0;
                end else begin
                    n_total = LW'(len16);
                end
            end

            p_plus4 = {1'b0, p} + (PW+1)'(4);
            crc_lim = (PW+1)'(11) + (PW+1)'(n_total);
            if (p < PW'(11) || p_plus4 < crc_lim) begin
                n_crc = crc_byte(n_crc, b);
            end
            n_stored = {n_stored[23:0], b};

            if (p >= PW'(11) && n_total >= LW'(6)) begin
                if (p == PW'(5) + PW'(n_total)) begin
                    n_crc_tlv_good = (b == 8'(CRC_TLV_CODE));
                end
                if (p == PW'(6) + PW'(n_total)) begin
                    n_crc_tlv_good = n_crc_tlv_good && (b == CRC_TLV_LEN);
                end
            end

            if (p >= PW'(11)) begin
                if (n_phase == PH_TYPE && p == n_next_off) begin
                    if (b == TLV_TYPE_NULL || b == TLV_TYPE_FF) begin
                        n_lookup = LKP_INVALID;
                        n_phase  = PH_DONE;
                    end else if (b == r_lookup_code) begin
                        n_lookup    = LKP_FOUND;
                        n_match_off = p;
                        n_phase     = PH_MLEN;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end else if (n_phase == PH_LEN) begin
                    nx = SW'(p) + SW'(b) + SW'(1);
                    n_next_off = (nx > SW'({PW{1'b1}})) ? {PW{1'b1}} : PW'(nx);
                    n_phase    = PH_TYPE;
                end else if (n_phase == PH_MLEN) begin
                    n_match_len = b;
                    n_phase     = PH_DONE;
                end
            end

            n_pos    = p + PW'(1);
            crc_out  = ~n_crc;
            end_pos  = PW'(10) + PW'(n_total);
            moff_ext = {11'd0, n_match_off};

            priority if (p == PW'(10) && !n_hdr_good) begin
                res_valid         = 1'b1;
                res.check_status  = CHK_BAD_HDR;
                res.lookup_status = LKP_NOT_FOUND;
                res.computed_crc  = crc_out;
                res.image_crc     = n_stored;
                n_active          = 1'b0;
            end else if (p >= PW'(10) && p == end_pos) begin
                res_valid = 1'b1;
                if (n_total < LW'(6) || !n_crc_tlv_good) begin
                    res.check_status = CHK_NO_CRC;
                end else if (crc_out != n_stored) begin
                    res.check_status = CHK_MISMATCH;
                end else begin
                    res.check_status = CHK_VALID;
                end
                res.lookup_status = n_lookup;
                if (n_lookup == LKP_FOUND) begin
                    res.found_offset = moff_ext[10:0];
                    res.found_length = n_match_len;
                end
                res.computed_crc = crc_out;
                res.image_crc    = n_stored;
                n_active         = 1'b0;
            end else begin
                res_valid = 1'b0;
            end
        end
    end

    always_comb begin
        n_ovalid     = r_ovalid;
        n_obeat      = r_obeat;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end
        if (r_skid_valid) begin
            if (!n_ovalid) begin
                n_ovalid     = 1'b1;
                n_obeat      = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (res_valid) begin
            if (!n_ovalid) begin
                n_ovalid = 1'b1;
                n_obeat  = res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookup_code  <= '0;
            r_pos          <= '0;
            r_active       <= 1'b0;
            r_hdr_good     <= 1'b0;
            r_total        <= '0;
            r_crc          <= '1;
            r_stored       <= '0;
            r_crc_tlv_good <= 1'b0;
            r_next_off     <= PW'(11);
            r_phase        <= PH_TYPE;
            r_lookup       <= LKP_NOT_FOUND;
            r_match_off    <= '0;
            r_match_len    <= '0;
            r_ovalid       <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_lookup_code <= i_cfg_data;
            end
            r_pos          <= n_pos;
            r_active       <= n_active;
            r_hdr_good     <= n_hdr_good;
            r_total        <= n_total;
            r_crc          <= n_crc;
            r_stored       <= n_stored;
            r_crc_tlv_good <= n_crc_tlv_good;
            r_next_off     <= n_next_off;
            r_phase        <= n_phase;
            r_lookup       <= n_lookup;
            r_match_off    <= n_match_off;
            r_match_len    <= n_match_len;
            r_ovalid       <= n_ovalid;
            r_skid_valid   <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_obeat <= n_obeat;
        r_skid  <= n_skid;
    end

endmodule

@@ hw/rtl/tlvchk_checker.sv @@
// Port-level assertions for tlvinfo_image_checker, attached by bind.
// Depends on tlvchk_pkg and the top level's port list.
`timescale 1ns / 1ps

module tlvchk_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input tlvchk_pkg::t_out_beat o_out_data
);
    import tlvchk_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

    a_bad_hdr_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.check_status == CHK_BAD_HDR |->
        o_out_data.lookup_status == LKP_NOT_FOUND &&
        o_out_data.found_offset == 11'd0 && o_out_data.found_length == 8'd0)
        else $error("bad header beat carries lookup data");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.lookup_status != LKP_FOUND |->
        o_out_data.found_offset == 11'd0 && o_out_data.found_length == 8'd0)
        else $error("lookup miss carries offset or length");

    a_valid_crc_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.check_status == CHK_VALID |->
        o_out_data.computed_crc == o_out_data.image_crc)
        else $error("valid status with unequal CRC values");

endmodule

bind tlvinfo_image_checker tlvchk_checker u_tlvchk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
